### rtl/core/induced_edge_sampler_unit_defines.svh
// ============================================================================
// induced_edge_sampler_unit_defines: assertion macros
// Shared concurrent-check forms, clocked on clk and held off during reset.
// ============================================================================
`ifndef INDUCED_EDGE_SAMPLER_UNIT_DEFINES_SVH
`define INDUCED_EDGE_SAMPLER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ies_pkg.sv
// ============================================================================
// ies_pkg: shared types and constants of the induced edge sampler
// Field widths, result status codes and configuration register indexes.
// ============================================================================
package ies_pkg;

    localparam int SLOT_W     = 18;
    localparam int NODE_W     = 16;
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [1:0] {
        ST_INDUCED  = 2'd0,
        ST_RANDOM   = 2'd1,
        ST_REJECTED = 2'd2,
        ST_MARKED   = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDIRECTED_MODE  = 1'd1;

endpackage

### rtl/core/ies_if.sv
// ============================================================================
// ies_if: item channels of the induced edge sampler
// Edge input channel and result output channel, valid/ready handshake.
// ============================================================================
interface ies_edge_if
    import ies_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] edge_slot;
    logic [SLOT_W-1:0] reverse_slot;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic [DRAW_W-1:0] rand_draw;

    modport source (
        output valid, edge_slot, reverse_slot, source_node, target_node, rand_draw,
        input  ready
    );

    modport sink (
        input  valid, edge_slot, reverse_slot, source_node, target_node, rand_draw,
        output ready
    );
endinterface

interface ies_result_if
    import ies_pkg::*;
();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;

    modport source (
        output valid, status, first_node, second_node,
        input  ready
    );

    modport sink (
        input  valid, status, first_node, second_node,
        output ready
    );
endinterface

### rtl/core/induced_edge_sampler_unit.sv
// ============================================================================
// induced_edge_sampler_unit: edge sampler with node and edge mark memories
// path: accepted edge passes 3 modulo stages, then the mark read and decision stage, then the result register
// items: the mark read of a new item waits until the previous item has left the decision stage
// reset: clearing pass over max(NODE_COUNT, EDGE_COUNT) mark addresses, no item taken meanwhile
// ============================================================================
`include "induced_edge_sampler_unit_defines.svh"

module induced_edge_sampler_unit
    import ies_pkg::*;
#(
    parameter int NODE_COUNT = 65536,
    parameter int EDGE_COUNT = 262144
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ies_edge_if.sink              edge_in,
    ies_result_if.source          result_out
);

    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int EDGE_AW   = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
    localparam int CLR_COUNT = (NODE_COUNT > EDGE_COUNT) ? NODE_COUNT : EDGE_COUNT;
    localparam int CLR_W     = $clog2(CLR_COUNT + 1);
    localparam int FR_DEPTH  = 3;
    localparam int FR_STEPS  = 6;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] rslot;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] src_red;
        logic [NODE_W-1:0] dst_red;
        logic [DRAW_W-1:0] draw;
    } fr_item_t;

    // one group of conditional subtractions of modulus shifted left
    function automatic logic [SLOT_W-1:0] mod_steps(input logic [SLOT_W-1:0] x,
                                                    input logic [63:0] modulus,
                                                    input int base);
        logic [SLOT_W-1:0] r;
        logic [63:0]       lim;
        r = x;
        for (int k = FR_STEPS - 1; k >= 0; k--)
        begin
            lim = modulus << (base + k);
            if ({{(64 - SLOT_W){1'b0}}, r} >= lim)
            begin
                r = r - lim[SLOT_W-1:0];
            end
        end
        return r;
    endfunction

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic             undir_reg;

    // clearing pass
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // modulo front stages
    fr_item_t            fr_reg  [FR_DEPTH];
    fr_item_t            fr_next [FR_DEPTH];
    logic [FR_DEPTH-1:0] fr_v_reg;
    logic [FR_DEPTH-1:0] fr_load;
    fr_item_t            in_item;
    logic                in_take;
    logic                core_take;

    // mark memories
    logic               node_mem [NODE_COUNT];
    logic               edge_mem [EDGE_COUNT];
    logic               node_rd_a_reg;
    logic               node_rd_b_reg;
    logic               edge_rd_reg;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    logic               mark_wdata;
    logic [NODE_AW-1:0] core_src_addr;
    logic [NODE_AW-1:0] core_dst_addr;
    logic [EDGE_AW-1:0] core_slot;
    logic [EDGE_AW-1:0] core_rslot;

    // decision stage
    logic               s1_valid_reg;
    logic [EDGE_AW-1:0] s1_slot_reg;
    logic [EDGE_AW-1:0] s1_rslot_reg;
    logic [NODE_AW-1:0] s1_src_addr_reg;
    logic [NODE_AW-1:0] s1_dst_addr_reg;
    logic [NODE_W-1:0]  s1_src_reg;
    logic [NODE_W-1:0]  s1_dst_reg;
    logic [DRAW_W-1:0]  s1_draw_reg;
    logic               s1_fire;
    logic               edge_mark;
    logic               src_mark;
    logic               dst_mark;
    status_t            s1_status;
    logic               s1_take;
    logic               s1_mark_nodes;
    logic               s1_swap;

    // second write of an item, in the cycle after its first
    logic               w2_pend_reg;
    logic               w2_node_en_reg;
    logic               w2_edge_en_reg;
    logic [NODE_AW-1:0] w2_node_addr_reg;
    logic [EDGE_AW-1:0] w2_edge_addr_reg;

    // result register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [NODE_W-1:0] out_first_reg;
    logic [NODE_W-1:0] out_second_reg;

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    assign core_take = fr_v_reg[FR_DEPTH-1] && !s1_valid_reg && !clearing_reg;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        fr_load[FR_DEPTH-1] = !fr_v_reg[FR_DEPTH-1] || core_take;
        for (int j = FR_DEPTH - 2; j >= 0; j--)
        begin
            fr_load[j] = !fr_v_reg[j] || fr_load[j+1];
        end
    end

    assign edge_in.ready = fr_load[0] && !clearing_reg;
    assign in_take       = edge_in.valid && edge_in.ready;

    assign in_item.slot    = edge_in.edge_slot;
    assign in_item.rslot   = edge_in.reverse_slot;
    assign in_item.src     = edge_in.source_node;
    assign in_item.dst     = edge_in.target_node;
    assign in_item.src_red = edge_in.source_node;
    assign in_item.dst_red = edge_in.target_node;
    assign in_item.draw    = edge_in.rand_draw;

    // each stage reduces slots and node addresses by one group of steps
    always_comb
    begin
        fr_item_t cur;
        for (int j = 0; j < FR_DEPTH; j++)
        begin
            cur = (j == 0) ? in_item : fr_reg[(j == 0) ? 0 : j - 1];
            fr_next[j] = cur;
            fr_next[j].slot    = mod_steps(cur.slot, 64'(EDGE_COUNT),
                                           FR_STEPS * (FR_DEPTH - 1 - j));
            fr_next[j].rslot   = mod_steps(cur.rslot, 64'(EDGE_COUNT),
                                           FR_STEPS * (FR_DEPTH - 1 - j));
            fr_next[j].src_red = NODE_W'(mod_steps(SLOT_W'(cur.src_red), 64'(NODE_COUNT),
                                                   FR_STEPS * (FR_DEPTH - 1 - j)));
            fr_next[j].dst_red = NODE_W'(mod_steps(SLOT_W'(cur.dst_red), 64'(NODE_COUNT),
                                                   FR_STEPS * (FR_DEPTH - 1 - j)));
        end
    end

    // ------------------------------------------------------------------------
    // mark memories
    // ------------------------------------------------------------------------
    assign core_src_addr = NODE_AW'(fr_reg[FR_DEPTH-1].src_red);
    assign core_dst_addr = NODE_AW'(fr_reg[FR_DEPTH-1].dst_red);
    assign core_slot     = EDGE_AW'(fr_reg[FR_DEPTH-1].slot);
    assign core_rslot    = EDGE_AW'(fr_reg[FR_DEPTH-1].rslot);

    always_comb
    begin
        mark_wdata = !clearing_reg;
        node_we    = 1'b0;
        edge_we    = 1'b0;
        node_waddr = s1_src_addr_reg;
        edge_waddr = s1_slot_reg;
        if (clearing_reg)
        begin
            node_we    = clr_cnt_reg < CLR_W'(NODE_COUNT);
            edge_we    = clr_cnt_reg < CLR_W'(EDGE_COUNT);
            node_waddr = clr_cnt_reg[NODE_AW-1:0];
            edge_waddr = clr_cnt_reg[EDGE_AW-1:0];
        end
        else if (s1_fire)
        begin
            node_we = s1_mark_nodes;
            edge_we = s1_take;
        end
        else if (w2_pend_reg)
        begin
            node_we    = w2_node_en_reg;
            edge_we    = w2_edge_en_reg;
            node_waddr = w2_node_addr_reg;
            edge_waddr = w2_edge_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= mark_wdata;
        end
        if (core_take)
        begin
            node_rd_a_reg <= node_mem[core_src_addr];
            node_rd_b_reg <= node_mem[core_dst_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= mark_wdata;
        end
        if (core_take)
        begin
            edge_rd_reg <= edge_mem[core_slot];
        end
    end

    // ------------------------------------------------------------------------
    // decision
    // ------------------------------------------------------------------------
    // forward the previous item's second write when it lands on the same edge or node as this read
    assign edge_mark = edge_rd_reg
                       || (w2_edge_en_reg && (w2_edge_addr_reg == s1_slot_reg));
    assign src_mark  = node_rd_a_reg
                       || (w2_node_en_reg && (w2_node_addr_reg == s1_src_addr_reg));
    assign dst_mark  = node_rd_b_reg
                       || (w2_node_en_reg && (w2_node_addr_reg == s1_dst_addr_reg));

    always_comb
    begin
        if (edge_mark)
        begin
            s1_status = ST_MARKED;
        end
        else if (src_mark && dst_mark)
        begin
            s1_status = ST_INDUCED;
        end
        else if (THR_W'(s1_draw_reg) < thr_reg)
        begin
            s1_status = ST_RANDOM;
        end
        else
        begin
            s1_status = ST_REJECTED;
        end
    end

    assign s1_take       = (s1_status == ST_INDUCED) || (s1_status == ST_RANDOM);
    assign s1_mark_nodes = (s1_status == ST_RANDOM);
    assign s1_swap       = undir_reg && (s1_dst_reg < s1_src_reg);

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= '0;
            undir_reg      <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            fr_v_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            w2_pend_reg    <= 1'b0;
            w2_node_en_reg <= 1'b0;
            w2_edge_en_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ACCEPT_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_UNDIRECTED_MODE:  undir_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (clearing_reg)
            begin
                clr_cnt_reg <= CLR_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == CLR_W'(CLR_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (fr_load[0])
            begin
                fr_v_reg[0] <= in_take;
            end
            for (int j = 1; j < FR_DEPTH; j++)
            begin
                if (fr_load[j])
                begin
                    fr_v_reg[j] <= fr_v_reg[j-1];
                end
            end

            if (core_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            w2_pend_reg <= s1_fire;
            if (s1_fire)
            begin
                w2_node_en_reg <= s1_mark_nodes;
                w2_edge_en_reg <= s1_take && undir_reg;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < FR_DEPTH; j++)
        begin
            if (fr_load[j])
            begin
                fr_reg[j] <= fr_next[j];
            end
        end

        if (core_take)
        begin
            s1_slot_reg     <= core_slot;
            s1_rslot_reg    <= core_rslot;
            s1_src_addr_reg <= core_src_addr;
            s1_dst_addr_reg <= core_dst_addr;
            s1_src_reg      <= fr_reg[FR_DEPTH-1].src;
            s1_dst_reg      <= fr_reg[FR_DEPTH-1].dst;
            s1_draw_reg     <= fr_reg[FR_DEPTH-1].draw;
        end

        if (s1_fire)
        begin
            w2_node_addr_reg <= s1_dst_addr_reg;
            w2_edge_addr_reg <= s1_rslot_reg;
            out_status_reg   <= s1_status;
            if (s1_take)
            begin
                out_first_reg  <= s1_swap ? s1_dst_reg : s1_src_reg;
                out_second_reg <= s1_swap ? s1_src_reg : s1_dst_reg;
            end
            else
            begin
                out_first_reg  <= '0;
                out_second_reg <= '0;
            end
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.status      = out_status_reg;
    assign result_out.first_node  = out_first_reg;
    assign result_out.second_node = out_second_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `IES_ASSERT_SAME(a_single_write_port, s1_fire, !w2_pend_reg, "two mark writes in one cycle")
    `IES_ASSERT_SAME(a_idle_while_clearing, clearing_reg, !s1_valid_reg && !out_valid_reg, "item in flight during clearing pass")
    `IES_ASSERT_NEXT(a_second_write_follows, s1_fire, w2_pend_reg && !s1_valid_reg, "second write not scheduled after result")
    `IES_ASSERT_SAME(a_skip_has_no_nodes, out_valid_reg && (out_status_reg == ST_MARKED || out_status_reg == ST_REJECTED), out_first_reg == '0 && out_second_reg == '0, "skipped item reports nodes")

endmodule
